// ===== rtl/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the feedback-queue scheduler
// Widths, opcodes, status codes, run-state codes, FSM state and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int LEVELS_DEF = 5;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 6;
    localparam int VALUE_W  = 4;
    localparam int STATUS_W = 2;
    localparam int LVL_W    = 3;
    localparam int QNT_W    = 4;
    localparam int PRIO_W   = 4;
    localparam int RS_W     = 3;
    localparam int PERIOD_W = 10;
    localparam int ENTRY_W  = 7;

    localparam logic [PERIOD_W-1:0] BOOST_RESET = 10'd100;
    localparam logic [VALUE_W-1:0]  PRIO_MAX    = 4'd10;
    localparam logic [VALUE_W-1:0]  RS_LAST     = 4'd5;

    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_STATE = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_PRIO  = 3'd2;
    localparam logic [OP_W-1:0] OP_PICK      = 3'd3;
    localparam logic [OP_W-1:0] OP_YIELD     = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BAD_PRIO  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NONE      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_STATE = 2'd3;

    localparam logic [RS_W-1:0] RS_UNUSED   = 3'd0;
    localparam logic [RS_W-1:0] RS_SLEEPING = 3'd2;
    localparam logic [RS_W-1:0] RS_RUNNABLE = 3'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_SCAN_START,
        S_SCAN,
        S_SETTLE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic op_modify;
        logic scan_start;
        logic scan_step;
        logic settle;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_pick;
        logic in_slot_op;
        logic scan_last;
        logic out_free;
    } stat_t;

    // quantum on entry to a level: 2*level+4, saturated to the field
    function automatic logic [QNT_W-1:0] quantum_of(input logic [LVL_W-1:0] lvl);
        logic [LVL_W+1:0] q;
        q = {1'b0, lvl, 1'b0} + (LVL_W+2)'(4);
        quantum_of = (q > (LVL_W+2)'(15)) ? QNT_W'(15) : QNT_W'(q);
    endfunction

endpackage

// ===== rtl/mlfq_ram.sv =====
// ----------------------------------------------------------------------------
// mlfq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfq_ctrl: sequencer of the scheduler
// Walks one beat through read-modify-write, the pick scan or, for tick and
// unknown ops, neither, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  mlfq_pkg::stat_t  stat,
    output mlfq_pkg::cmd_t   cmd
);

    mlfq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlfq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            mlfq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (stat.in_pick) begin
                        state_next = mlfq_pkg::S_SCAN_START;
                    end else if (stat.in_slot_op) begin
                        state_next = mlfq_pkg::S_READ;
                    end else begin
                        state_next = mlfq_pkg::S_DONE;
                    end
                end
            end
            mlfq_pkg::S_READ: begin
                state_next = mlfq_pkg::S_MODIFY;
            end
            mlfq_pkg::S_MODIFY: begin
                cmd.op_modify = 1'b1;
                state_next    = mlfq_pkg::S_DONE;
            end
            mlfq_pkg::S_SCAN_START: begin
                cmd.scan_start = 1'b1;
                state_next     = mlfq_pkg::S_SCAN;
            end
            mlfq_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = mlfq_pkg::S_SETTLE;
                end
            end
            mlfq_pkg::S_SETTLE: begin
                cmd.settle = 1'b1;
                state_next = mlfq_pkg::S_DONE;
            end
            mlfq_pkg::S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mlfq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mlfq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mlfq_dp.sv =====
// ----------------------------------------------------------------------------
// mlfq_dp: scheduler datapath
// Task and level tables, per-slot valid bits, tick/boost counter, per-level
// best-candidate trackers, cursor and output register.
// ----------------------------------------------------------------------------
module mlfq_dp #(
    parameter int SLOTS  = mlfq_pkg::SLOTS_DEF,
    parameter int LEVELS = mlfq_pkg::LEVELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mlfq_pkg::cmd_t                  cmd,
    output mlfq_pkg::stat_t                 stat,
    input  logic [mlfq_pkg::OP_W-1:0]       in_op,
    input  logic [mlfq_pkg::SLOT_W-1:0]     in_slot,
    input  logic [mlfq_pkg::VALUE_W-1:0]    in_value,
    input  logic                            cfg_we,
    input  logic [mlfq_pkg::PERIOD_W-1:0]   cfg_wdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [mlfq_pkg::STATUS_W-1:0]   out_status,
    output logic [mlfq_pkg::SLOT_W-1:0]     out_chosen,
    output logic [mlfq_pkg::LVL_W-1:0]      out_level
);

    localparam int AW = $clog2(SLOTS);
    localparam int LW = mlfq_pkg::LVL_W;
    localparam int QW = mlfq_pkg::QNT_W;
    localparam int PW = mlfq_pkg::PRIO_W;
    localparam int EW = mlfq_pkg::ENTRY_W;
    localparam logic [QW-1:0] Q0 = mlfq_pkg::quantum_of(LW'(0));

    // captured beat
    logic [mlfq_pkg::OP_W-1:0]    op_reg;
    logic [mlfq_pkg::SLOT_W-1:0]  slot_reg;
    logic [mlfq_pkg::VALUE_W-1:0] value_reg;
    logic [AW-1:0]                slot_idx;

    // config, tick, boost, cursor
    logic [mlfq_pkg::PERIOD_W-1:0] period_reg;
    logic [mlfq_pkg::PERIOD_W-1:0] tick_reg;
    logic [mlfq_pkg::PERIOD_W-1:0] tick_inc;
    logic                          pending_reg;
    logic [AW-1:0]                 cursor_reg;

    // tables
    logic [SLOTS-1:0] tvalid_reg;
    logic [SLOTS-1:0] lvalid_reg;
    logic             tv_q, lv_q;
    logic             t_we, l_we;
    logic [AW-1:0]    t_waddr, l_waddr, raddr;
    logic [EW-1:0]    t_wdata, l_wdata, t_rdata, l_rdata;
    logic             clear_all;

    // scan
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] rd_addr_inc;
    logic [AW-1:0] count_reg;

    // trackers, one per level
    logic          found_reg [LEVELS];
    logic [AW-1:0] best_slot_reg [LEVELS];
    logic [PW-1:0] best_prio_reg [LEVELS];
    logic [QW-1:0] best_qnt_reg [LEVELS];

    // result
    logic [mlfq_pkg::STATUS_W-1:0] res_status_reg;
    logic [mlfq_pkg::SLOT_W-1:0]   res_chosen_reg;
    logic [LW-1:0]                 res_level_reg;
    logic                          m_tvalid_reg;
    logic [mlfq_pkg::STATUS_W-1:0] m_status_reg;
    logic [mlfq_pkg::SLOT_W-1:0]   m_chosen_reg;
    logic [LW-1:0]                 m_level_reg;

    // current entry as read
    logic [mlfq_pkg::RS_W-1:0] rs_cur;
    logic [PW-1:0]             prio_cur;
    logic [LW-1:0]             lvl_cur, lvl_new;
    logic [QW-1:0]             q_cur, q_new;
    logic                      cand;

    // settle
    logic          any_found;
    logic [LW-1:0] sel_lvl;
    logic [AW-1:0] win_slot;
    logic [QW-1:0] win_qnt;

    assign slot_idx   = AW'(slot_reg);
    assign tick_inc   = tick_reg + mlfq_pkg::PERIOD_W'(1);
    assign rd_addr_inc = (32'(rd_addr_reg) == SLOTS - 1) ? '0 : rd_addr_reg + AW'(1);

    assign rs_cur   = tv_q ? t_rdata[EW-1:PW] : mlfq_pkg::RS_UNUSED;
    assign prio_cur = tv_q ? t_rdata[PW-1:0] : '0;
    assign lvl_cur  = lv_q ? l_rdata[EW-1:QW] : '0;
    assign q_cur    = lv_q ? l_rdata[QW-1:0] : Q0;

    always_comb begin
        lvl_new = lvl_cur;
        q_new   = q_cur;
        if ((32'(lvl_cur) + 1 < LEVELS) && (q_cur == '0)) begin
            lvl_new = lvl_cur + LW'(1);
            q_new   = mlfq_pkg::quantum_of(lvl_cur + LW'(1));
        end
        if (rs_cur == mlfq_pkg::RS_SLEEPING) begin
            lvl_new = '0;
            q_new   = Q0;
        end
    end

    assign cand = (rs_cur == mlfq_pkg::RS_RUNNABLE) && (q_new != '0);

    always_comb begin
        any_found = 1'b0;
        sel_lvl   = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (found_reg[l]) begin
                any_found = 1'b1;
                sel_lvl   = LW'(l);
            end
        end
    end

    assign win_slot = best_slot_reg[sel_lvl];
    assign win_qnt  = best_qnt_reg[sel_lvl];

    assign stat.in_pick    = (in_op == mlfq_pkg::OP_PICK);
    assign stat.in_slot_op = ((in_op == mlfq_pkg::OP_SET_STATE) ||
                              (in_op == mlfq_pkg::OP_SET_PRIO) ||
                              (in_op == mlfq_pkg::OP_YIELD)) && (32'(in_slot) < SLOTS);
    assign stat.scan_last  = (32'(count_reg) == SLOTS - 1);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign clear_all = (cmd.scan_start && pending_reg) || (cmd.settle && !any_found);

    // table read address and write ports
    always_comb begin
        raddr   = slot_idx;
        t_we    = 1'b0;
        t_waddr = slot_idx;
        t_wdata = {rs_cur, prio_cur};
        l_we    = 1'b0;
        l_waddr = slot_idx;
        l_wdata = {lvl_cur, q_cur};
        if (cmd.scan_start) begin
            raddr = cursor_reg;
        end else if (cmd.scan_step) begin
            raddr   = rd_addr_inc;
            l_we    = 1'b1;
            l_waddr = rd_addr_reg;
            l_wdata = {lvl_new, q_new};
        end else if (cmd.settle) begin
            l_we    = any_found;
            l_waddr = win_slot;
            l_wdata = {sel_lvl, win_qnt - QW'(1)};
        end else if (cmd.op_modify) begin
            case (op_reg)
                mlfq_pkg::OP_SET_STATE: begin
                    t_we    = (value_reg <= mlfq_pkg::RS_LAST);
                    t_wdata = {value_reg[mlfq_pkg::RS_W-1:0], prio_cur};
                end
                mlfq_pkg::OP_SET_PRIO: begin
                    t_we    = (value_reg <= mlfq_pkg::PRIO_MAX);
                    t_wdata = {rs_cur, value_reg};
                end
                mlfq_pkg::OP_YIELD: begin
                    t_we    = 1'b1;
                    t_wdata = {mlfq_pkg::RS_RUNNABLE, prio_cur};
                    l_we    = 1'b1;
                    l_wdata = {LW'(0), Q0};
                end
                default: begin
                    t_we = 1'b0;
                end
            endcase
        end
    end

    mlfq_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_task_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (raddr),
        .rdata (t_rdata)
    );

    mlfq_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_level_ram (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (raddr),
        .rdata (l_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= mlfq_pkg::BOOST_RESET;
            tick_reg     <= '0;
            pending_reg  <= 1'b0;
            cursor_reg   <= '0;
            tvalid_reg   <= '0;
            lvalid_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                found_reg[l] <= 1'b0;
            end
        end else begin
            if (cfg_we) begin
                period_reg <= cfg_wdata;
            end
            if (cmd.load && in_op == mlfq_pkg::OP_TICK) begin
                if (tick_inc == period_reg) begin
                    tick_reg    <= '0;
                    pending_reg <= 1'b1;
                end else begin
                    tick_reg <= tick_inc;
                end
            end else if (cmd.scan_start) begin
                pending_reg <= 1'b0;
            end
            if (t_we) begin
                tvalid_reg[t_waddr] <= 1'b1;
            end
            if (clear_all) begin
                lvalid_reg <= '0;
            end else if (l_we) begin
                lvalid_reg[l_waddr] <= 1'b1;
            end
            if (cmd.settle && any_found) begin
                cursor_reg <= (32'(win_slot) == SLOTS - 1) ? '0 : win_slot + AW'(1);
            end
            for (int l = 0; l < LEVELS; l++) begin
                if (cmd.scan_start) begin
                    found_reg[l] <= 1'b0;
                end else if (cmd.scan_step && cand && lvl_new == LW'(l) &&
                             (!found_reg[l] || prio_cur > best_prio_reg[l])) begin
                    found_reg[l] <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tv_q <= tvalid_reg[raddr];
        lv_q <= lvalid_reg[raddr] & ~clear_all;
        if (cmd.load) begin
            op_reg         <= in_op;
            slot_reg       <= in_slot;
            value_reg      <= in_value;
            res_status_reg <= mlfq_pkg::STS_OK;
            res_chosen_reg <= '0;
            res_level_reg  <= '0;
        end
        if (cmd.scan_start) begin
            rd_addr_reg <= cursor_reg;
            count_reg   <= '0;
        end else if (cmd.scan_step) begin
            rd_addr_reg <= rd_addr_inc;
            count_reg   <= count_reg + AW'(1);
        end
        for (int l = 0; l < LEVELS; l++) begin
            if (cmd.scan_step && cand && lvl_new == LW'(l) &&
                (!found_reg[l] || prio_cur > best_prio_reg[l])) begin
                best_slot_reg[l] <= rd_addr_reg;
                best_prio_reg[l] <= prio_cur;
                best_qnt_reg[l]  <= q_new;
            end
        end
        if (cmd.settle) begin
            if (any_found) begin
                res_chosen_reg <= mlfq_pkg::SLOT_W'(win_slot);
                res_level_reg  <= sel_lvl;
            end else begin
                res_status_reg <= mlfq_pkg::STS_NONE;
            end
        end
        if (cmd.op_modify) begin
            case (op_reg)
                mlfq_pkg::OP_SET_STATE: begin
                    if (value_reg > mlfq_pkg::RS_LAST) begin
                        res_status_reg <= mlfq_pkg::STS_BAD_STATE;
                    end else begin
                        res_level_reg <= lvl_cur;
                    end
                end
                mlfq_pkg::OP_SET_PRIO: begin
                    if (value_reg > mlfq_pkg::PRIO_MAX) begin
                        res_status_reg <= mlfq_pkg::STS_BAD_PRIO;
                    end else begin
                        res_level_reg <= lvl_cur;
                    end
                end
                default: begin
                    res_level_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_chosen_reg <= res_chosen_reg;
            m_level_reg  <= res_level_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_status = m_status_reg;
    assign out_chosen = m_chosen_reg;
    assign out_level  = m_level_reg;

    // scan write-back never lands on the slot being fetched
    a_scan_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (l_waddr != raddr))
        else $error("scan write-back collides with read address");

    // a pending boost is consumed when a pick starts its scan
    a_boost_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |=> !pending_reg)
        else $error("boost still pending after scan start");

    // a winner always sits on a real level
    a_winner_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.settle && any_found) |=> (32'(res_level_reg) < LEVELS))
        else $error("winner level out of range");

    // an empty pick leaves every level entry reading as boosted
    a_empty_boost: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.settle && !any_found) |=> (lvalid_reg == '0))
        else $error("level table not boosted after empty pick");

endmodule

// ===== rtl/mlfq_process_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// mlfq_process_scheduler_unit: multilevel feedback queue task scheduler
// Task table of SLOTS entries over LEVELS feedback levels with tick-driven
// global boosts, quantum demotion and cursor-rotated priority picks.
//
//   channel   dir   bits  contents (low bit first)
//   s_*       in    16    op[2:0] slot[8:3] value[12:9]
//   m_*       out   16    status[1:0] chosen_slot[7:2] slot_level[10:8]
//   cfg_*     in    10    boost_period
//
// Path: tick and unknown ops go straight to the output register, slot ops
//   (set state, set priority, yield) through read and modify, a pick through
//   scan start, a scan pass of one table read per cycle, and settle.
// Reset: aresetn low clears all control state; tables read as their reset
//   values through per-slot valid bits, so no clearing pass is needed.
// Stalls: one beat in flight; s_tready is high only while idle, and a
//   finished result waits in the output register for m_tready.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler_unit #(
    parameter int SLOTS  = mlfq_pkg::SLOTS_DEF,
    parameter int LEVELS = mlfq_pkg::LEVELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // op[2:0], slot[8:3], value[12:9], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // status[1:0], chosen_slot[7:2], slot_level[10:8]
    input  logic        cfg_we,
    input  logic [mlfq_pkg::PERIOD_W-1:0] cfg_wdata
);

    mlfq_pkg::cmd_t  cmd;
    mlfq_pkg::stat_t stat;

    logic [mlfq_pkg::STATUS_W-1:0] out_status;
    logic [mlfq_pkg::SLOT_W-1:0]   out_chosen;
    logic [mlfq_pkg::LVL_W-1:0]    out_level;

    mlfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlfq_dp #(.SLOTS(SLOTS), .LEVELS(LEVELS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tdata[2:0]),
        .in_slot    (s_tdata[8:3]),
        .in_value   (s_tdata[12:9]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_chosen (out_chosen),
        .out_level  (out_level)
    );

    assign m_tdata = {5'd0, out_level, out_chosen, out_status};

endmodule

// ===== dv/tb_mlfq_process_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mlfq_process_scheduler_unit: self-checking bench for the MLFQ scheduler
// Drives tick, set-state, set-priority, pick and yield beats with random
// stalls on both streams. Each accepted beat runs through an in-bench model
// of the task table. Every result beat is checked field by field against
// the oldest expected result.
// ----------------------------------------------------------------------------
module tb_mlfq_process_scheduler_unit;

    localparam int NSLOT = mlfq_pkg::SLOTS_DEF;
    localparam int NLVL  = mlfq_pkg::LEVELS_DEF;
    localparam int OW    = mlfq_pkg::OP_W;
    localparam int SW    = mlfq_pkg::SLOT_W;
    localparam int VW    = mlfq_pkg::VALUE_W;
    localparam int QW    = mlfq_pkg::QNT_W;
    localparam int PW    = mlfq_pkg::PERIOD_W;
    localparam logic [OW-1:0] OP_UNDEF_LO  = 3'd5;   // 5..7 are no-ops
    localparam logic [OW-1:0] OP_UNDEF_MID = 3'd6;
    localparam logic [OW-1:0] OP_UNDEF_HI  = 3'd7;

    typedef struct packed {
        logic [mlfq_pkg::STATUS_W-1:0] status;
        logic [SW-1:0]                 chosen;
        logic [mlfq_pkg::LVL_W-1:0]    level;
    } sched_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [PW-1:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    mlfq_process_scheduler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // ---- shadow task table ----
    logic [mlfq_pkg::RS_W-1:0]   tbl_state [NSLOT];
    logic [mlfq_pkg::LVL_W-1:0]  tbl_level [NSLOT];
    logic [QW-1:0]               tbl_qnt   [NSLOT];
    logic [mlfq_pkg::PRIO_W-1:0] tbl_prio  [NSLOT];
    logic [PW-1:0]               tick_cnt;
    logic                        boost_due;
    logic [SW-1:0]               cursor;
    logic [PW-1:0]               period;

    sched_res_t expected_results[$];
    int  mismatches = 0;
    bit  calm = 1'b0;        // when set, neither side stalls

    function automatic logic [QW-1:0] level_quantum(input int lvl);
        int q;
        q = 2 * lvl + 4;
        return (q > 15) ? QW'(15) : QW'(q);
    endfunction

    function automatic void boost_table();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_level[i] = '0;
            tbl_qnt[i] = level_quantum(0);
        end
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_state[i] = mlfq_pkg::RS_UNUSED;
            tbl_prio[i] = '0;
        end
        boost_table();
        tick_cnt = '0;
        boost_due = 1'b0;
        cursor = '0;
        period = mlfq_pkg::BOOST_RESET;
    endfunction

    // one beat through the scheduler model
    function automatic sched_res_t schedule_step(input logic [OW-1:0] op,
                                                 input logic [SW-1:0] slot,
                                                 input logic [VW-1:0] value);
        sched_res_t r;
        int low;
        int win;
        bit found;
        int idx;
        r = '0;
        case (op)
            mlfq_pkg::OP_TICK: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt == period) begin
                    tick_cnt = '0;
                    boost_due = 1'b1;
                end
            end
            mlfq_pkg::OP_PICK: begin
                if (boost_due) begin
                    boost_table();
                    boost_due = 1'b0;
                end
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_level[i] + 1 < NLVL && tbl_qnt[i] == 0) begin
                        tbl_level[i] = tbl_level[i] + 1'b1;
                        tbl_qnt[i] = level_quantum(tbl_level[i]);
                    end
                    if (tbl_state[i] == mlfq_pkg::RS_SLEEPING) begin
                        tbl_level[i] = '0;
                        tbl_qnt[i] = level_quantum(0);
                    end
                end
                low = NLVL;
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_state[i] == mlfq_pkg::RS_RUNNABLE && tbl_qnt[i] != 0 &&
                        tbl_level[i] < low)
                        low = tbl_level[i];
                if (low >= NLVL) begin
                    boost_table();
                    r.status = mlfq_pkg::STS_NONE;
                end else begin
                    found = 1'b0;
                    win = 0;
                    for (int k = 0; k < NSLOT; k++) begin
                        idx = (cursor + k) % NSLOT;
                        if (tbl_state[idx] == mlfq_pkg::RS_RUNNABLE && tbl_qnt[idx] != 0 &&
                            tbl_level[idx] == low &&
                            (!found || tbl_prio[idx] > tbl_prio[win])) begin
                            win = idx;
                            found = 1'b1;
                        end
                    end
                    if (tbl_qnt[win] != 0) tbl_qnt[win] = tbl_qnt[win] - 1'b1;
                    cursor = SW'((win + 1) % NSLOT);
                    r.chosen = SW'(win);
                    r.level = tbl_level[win];
                end
            end
            mlfq_pkg::OP_SET_STATE: begin
                if (value > mlfq_pkg::RS_LAST) r.status = mlfq_pkg::STS_BAD_STATE;
                else begin
                    tbl_state[slot] = value[mlfq_pkg::RS_W-1:0];
                    r.level = tbl_level[slot];
                end
            end
            mlfq_pkg::OP_SET_PRIO: begin
                if (value > mlfq_pkg::PRIO_MAX) r.status = mlfq_pkg::STS_BAD_PRIO;
                else begin
                    tbl_prio[slot] = value;
                    r.level = tbl_level[slot];
                end
            end
            mlfq_pkg::OP_YIELD: begin
                tbl_state[slot] = mlfq_pkg::RS_RUNNABLE;
                tbl_level[slot] = '0;
                tbl_qnt[slot] = level_quantum(0);
                r.level = '0;
            end
            default: ;   // unknown ops change nothing
        endcase
        return r;
    endfunction

    function automatic bit stall_now();
        return !calm && ($urandom_range(99) < 13);
    endfunction

    // ---- input driver: one beat, stalls on falling edges ----
    task automatic send_beat(input logic [OW-1:0] op, input logic [SW-1:0] slot,
                             input logic [VW-1:0] value);
        bit done;
        done = 1'b0;
        @(negedge aclk);
        while (stall_now()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, value, slot, op};
        while (!done) begin
            @(posedge aclk);
            if (s_tready) begin
                done = 1'b1;
                expected_results.push_back(schedule_step(op, slot, value));
            end else
                @(negedge aclk);
        end
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // register write with the block idle
    task automatic write_period(input logic [PW-1:0] p);
        wait_drained();
        repeat (NSLOT + 8) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= p;
        @(negedge aclk);
        cfg_we <= 1'b0;
        period = p;
    endtask

    // ---- output side: random stalls, compare on accepted beats ----
    always @(negedge aclk) m_tready <= !stall_now();

    always @(posedge aclk) begin
        sched_res_t got;
        sched_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.chosen = m_tdata[7:2];
            got.level = m_tdata[10:8];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d slot %0d level %0d",
                             got.status, got.chosen, got.level);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp status %0d slot %0d level %0d, got %0d %0d %0d",
                                 want.status, want.chosen, want.level,
                                 got.status, got.chosen, got.level);
                end
            end
        end
    end

    // ---- tests ----
    task automatic test_directed();
        send_beat(mlfq_pkg::OP_PICK, '0, '0);               // empty table: nothing runnable
        send_beat(mlfq_pkg::OP_SET_STATE, 6'd63, 4'd6);     // bad state codes
        send_beat(mlfq_pkg::OP_SET_STATE, 6'd0, 4'd15);
        send_beat(mlfq_pkg::OP_SET_PRIO, 6'd63, 4'd11);     // priority out of range
        send_beat(mlfq_pkg::OP_SET_PRIO, 6'd0, 4'd15);
        send_beat(mlfq_pkg::OP_SET_PRIO, 6'd63, 4'd10);
        send_beat(mlfq_pkg::OP_SET_STATE, 6'd63, VW'(mlfq_pkg::RS_RUNNABLE));
        send_beat(mlfq_pkg::OP_YIELD, 6'd0, 4'd0);
        send_beat(mlfq_pkg::OP_SET_STATE, 6'd42, VW'(mlfq_pkg::RS_SLEEPING));
        send_beat(mlfq_pkg::OP_SET_STATE, 6'd21, 4'd5);
        send_beat(mlfq_pkg::OP_PICK, '0, '0);               // priority wins over cursor
        send_beat(mlfq_pkg::OP_PICK, '0, '0);
        send_beat(mlfq_pkg::OP_SET_PRIO, 6'd0, 4'd10);
        send_beat(mlfq_pkg::OP_PICK, '0, '0);               // tie: rotate from cursor
        send_beat(mlfq_pkg::OP_PICK, '0, '0);
        send_beat(OP_UNDEF_LO, 6'd63, 4'd15);               // unknown ops
        send_beat(OP_UNDEF_MID, 6'd1, 4'd1);
        send_beat(OP_UNDEF_HI, 6'd2, 4'd2);
        send_beat(mlfq_pkg::OP_TICK, 6'd63, 4'd15);
        send_beat(mlfq_pkg::OP_TICK, '0, '0);
        send_beat(mlfq_pkg::OP_PICK, '0, '0);               // pending boost from period 1
        send_beat(mlfq_pkg::OP_SET_STATE, 6'd63, 4'd0);
        send_beat(mlfq_pkg::OP_SET_STATE, 6'd0, 4'd4);
        send_beat(mlfq_pkg::OP_PICK, '0, '0);
    endtask

    // mostly a handful of live slots so quanta run out and levels deepen
    task automatic test_random(input int n);
        logic [OW-1:0] op;
        logic [SW-1:0] slot;
        logic [VW-1:0] value;
        int w;
        for (int i = 0; i < n; i++) begin
            w = $urandom_range(99);
            slot = ($urandom_range(9) == 0) ? SW'($urandom) : SW'($urandom_range(5));
            value = ($urandom_range(7) == 0) ? VW'($urandom)
                                             : VW'($urandom_range(5));
            if (w < 38) op = mlfq_pkg::OP_PICK;
            else if (w < 60) op = mlfq_pkg::OP_TICK;
            else if (w < 74) begin
                op = mlfq_pkg::OP_SET_STATE;
                if (value <= mlfq_pkg::RS_LAST && $urandom_range(2) == 0)
                    value = VW'(mlfq_pkg::RS_RUNNABLE);
            end else if (w < 85) begin
                op = mlfq_pkg::OP_SET_PRIO;
                value = ($urandom_range(7) == 0) ? VW'($urandom)
                                                 : VW'($urandom_range(10));
            end else if (w < 95) op = mlfq_pkg::OP_YIELD;
            else op = OW'($urandom_range(7, OP_UNDEF_LO));
            send_beat(op, slot, value);
        end
    endtask

    initial begin
        reset_table();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_period(10'd1);
        test_directed();
        write_period(10'd100);
        test_random(350);
        write_period(10'd1023);
        calm = 1'b1;                  // long stretch with no stalls
        test_random(400);
        calm = 1'b0;
        write_period(10'd3);
        test_random(350);
        wait_drained();               // sender holds off until all results are in
        write_period(10'd1);
        test_random(350);
        write_period(PW'($urandom_range(1023, 1)));
        test_random(375);

        wait_drained();
        repeat (NSLOT + 20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
